[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/srps_pkg.sv]
// ---------------------------------------------------------------------------
// srps_pkg
// Types, codes and constants of the stepper ramp pulse sequencer.
// ---------------------------------------------------------------------------
package srps_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_TIMER_CLOCK = 1000000;
  localparam int STEP_BITS       = 24;
  localparam int POS_W1          = STEP_BITS + 1;
  localparam int RLEN_W          = 12;
  localparam int SPEED_W         = 16;
  localparam int IDX_W           = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [SPEED_W-1:0] SHORT_HALF = 16'd1500;
  localparam logic [SPEED_W-1:0] HALF_MAX   = 16'hFFFF;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CMP   = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD = 2'd1;

  typedef enum logic [1:0] {
    PH_STOP,
    PH_ACCEL,
    PH_CRUISE,
    PH_DECEL
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [SPEED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] half;
  } div_rsp_t;

endpackage

[hdl/srps_ram.sv]
// ---------------------------------------------------------------------------
// srps_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module srps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/srps_div.sv]
// ---------------------------------------------------------------------------
// srps_div
// Serial restoring divider: timer clock / speed, halved, saturated to 16 bit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srps_div import srps_pkg::*; #(
  parameter int TIMER_CLOCK = DEF_TIMER_CLOCK
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DW = $clog2(TIMER_CLOCK + 1);
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] DIVIDEND = DW'(TIMER_CLOCK);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SPEED_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [SPEED_W-1:0] dsr_r, dsr_nxt;

  logic [SPEED_W:0]   trial;
  logic               ge;
  logic [31:0]        qh;

  assign trial = {rem_r, DIVIDEND[cnt_r]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign qh    = 32'(quo_r >> 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      rem_nxt  = '0;
      quo_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? SPEED_W'(trial - {1'b0, dsr_r}) : SPEED_W'(trial);
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.half = (|qh[31:16]) ? HALF_MAX : qh[15:0];

  `ASSERT_NEVER(a_div_start_busy, req.start && busy_r, "divider restarted while busy")
  `ASSERT_NEVER(a_div_zero, req.start && (req.divisor == '0), "divider started with zero speed")
  `ASSERT_CLK(a_div_done_busy, done_r |-> $past(busy_r), "divider done without a run")

endmodule

[hdl/stepper_ramp_pulse_sequencer.sv]
// ---------------------------------------------------------------------------
// stepper_ramp_pulse_sequencer
// Step pulse sequencer with ramp table, trapezoid phases and serial divider.
// ---------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | func, entry_index, entry_speed,
//         |           |                     | move_steps, move_dir
// out     | output    | out_valid/out_ready | accepted .. finished, one beat
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Loads, stops, rejected starts, short-mode and cruise events go through ST_EXEC and ST_OUT.
// Beats needing a new half-period also wait in ST_DIV for the serial divider,
// which works at one quotient bit per cycle.
// Synchronous reset, no clearing pass; speed table undefined until loaded.
// A result held by out_ready low lets one further beat be taken and worked;
// that one then waits for the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_ramp_pulse_sequencer import srps_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int TIMER_CLOCK = DEF_TIMER_CLOCK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [SPEED_W-1:0]    in_entry_speed,
  input  logic [STEP_BITS-1:0]  in_move_steps,
  input  logic                  in_move_dir,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic                  out_step_level,
  output logic                  out_direction,
  output logic                  out_enable,
  output logic [1:0]            out_phase,
  output logic                  out_compare_relative,
  output logic [SPEED_W-1:0]    out_compare_value,
  output logic [STEP_BITS-1:0]  out_position,
  output logic                  out_finished,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [STEP_BITS-1:0] pos_r, pos_nxt;
  logic [STEP_BITS-1:0] total_r, total_nxt;
  logic [STEP_BITS-1:0] decel_r, decel_nxt;
  logic [SPEED_W-1:0]   half_r, half_nxt;
  logic                 short_r, short_nxt;
  logic                 tog_r, tog_nxt;
  logic                 level_r, level_nxt;
  logic                 dir_r, dir_nxt;
  logic [RLEN_W-1:0]    rlen_r, rlen_nxt;
  logic [10:0]          ramp_steps_r;
  logic [SPEED_W-1:0]   reload_r;

  logic [1:0]           func_q_r, func_q_nxt;
  logic [STEP_BITS-1:0] steps_q_r, steps_q_nxt;
  logic                 dir_q_r, dir_q_nxt;

  logic                 acc_p_r, acc_p_nxt;
  logic                 rel_p_r, rel_p_nxt;
  logic [SPEED_W-1:0]   cval_p_r, cval_p_nxt;
  logic                 fin_p_r, fin_p_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 need_div;

  logic                 in_fire;
  logic                 tbl_we;
  logic [AW-1:0]        tbl_raddr;
  logic [SPEED_W-1:0]   ram_rdata;

  logic [RLEN_W-1:0]    ramp_even;
  logic                 start_fit;
  logic                 start_ramp;
  logic                 start_ok;
  logic [POS_W1-1:0]    pos_inc;
  logic                 pos_reach_total;
  logic                 pos_reach_rlen;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign in_fire   = in_valid && in_ready;
  assign tbl_we    = in_fire && (in_func == FUNC_LOAD) && (32'(in_entry_index) < TABLE_DEPTH);
  assign tbl_raddr = (in_func == FUNC_START) ? '0 : ptr_r;

  srps_ram #(
    .WIDTH (SPEED_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_entry_speed),
    .re    (in_fire),
    .raddr (tbl_raddr),
    .rdata (ram_rdata)
  );

  srps_div #(
    .TIMER_CLOCK (TIMER_CLOCK)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ramp_even  = (RLEN_W'({1'b0, ramp_steps_r}) + 12'd1) & ~12'd1;
  assign start_fit  = 32'(ramp_even) <= TABLE_DEPTH;
  assign start_ramp = {1'b0, steps_q_r} >= POS_W1'({ramp_even, 1'b0});
  assign start_ok   = (steps_q_r != '0) && (phase_r == PH_STOP) && start_fit
                      && !(start_ramp && (ram_rdata == '0));

  assign pos_inc         = POS_W1'(pos_r) + 1'b1;
  assign pos_reach_total = pos_inc >= POS_W1'(total_r);
  assign pos_reach_rlen  = pos_inc >= POS_W1'(rlen_r);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    ptr_nxt     = ptr_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    decel_nxt   = decel_r;
    half_nxt    = half_r;
    short_nxt   = short_r;
    tog_nxt     = tog_r;
    level_nxt   = level_r;
    dir_nxt     = dir_r;
    rlen_nxt    = rlen_r;
    func_q_nxt  = func_q_r;
    steps_q_nxt = steps_q_r;
    dir_q_nxt   = dir_q_r;
    acc_p_nxt   = acc_p_r;
    rel_p_nxt   = rel_p_r;
    cval_p_nxt  = cval_p_r;
    fin_p_nxt   = fin_p_r;
    need_div    = 1'b0;
    out_load    = 1'b0;
    in_ready    = (state_r == ST_IDLE);
    div_req.start   = 1'b0;
    div_req.divisor = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_q_nxt  = in_func;
          steps_q_nxt = in_move_steps;
          dir_q_nxt   = in_move_dir;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_p_nxt  = 1'b0;
        rel_p_nxt  = 1'b0;
        cval_p_nxt = '0;
        fin_p_nxt  = 1'b0;
        case (func_q_r)
          FUNC_START: begin
            if (start_ok) begin
              acc_p_nxt = 1'b1;
              dir_nxt   = dir_q_r;
              total_nxt = steps_q_r;
              rlen_nxt  = ramp_even;
              pos_nxt   = '0;
              ptr_nxt   = '0;
              tog_nxt   = 1'b0;
              rel_p_nxt = 1'b1;
              if (start_ramp) begin
                short_nxt = 1'b0;
                decel_nxt = steps_q_r - STEP_BITS'(ramp_even);
                phase_nxt = PH_ACCEL;
                need_div  = 1'b1;
              end else begin
                short_nxt  = 1'b1;
                decel_nxt  = '0;
                phase_nxt  = PH_CRUISE;
                half_nxt   = SHORT_HALF;
                cval_p_nxt = SHORT_HALF;
              end
            end
          end
          FUNC_CMP: begin
            if (phase_r != PH_STOP) begin
              level_nxt = ~level_r;
              tog_nxt   = ~tog_r;
              if (tog_r) begin
                if (short_r) begin
                  if ((phase_r == PH_CRUISE) && pos_reach_total) begin
                    fin_p_nxt = 1'b1;
                  end
                end else begin
                  case (phase_r)
                    PH_ACCEL: begin
                      if (pos_reach_rlen) begin
                        phase_nxt = PH_CRUISE;
                        if (ptr_r != '0) begin
                          ptr_nxt = ptr_r - 1'b1;
                        end
                      end else begin
                        if (ram_rdata == '0) begin
                          half_nxt = HALF_MAX;
                        end else begin
                          need_div = 1'b1;
                        end
                        ptr_nxt = ptr_r + 1'b1;
                      end
                    end
                    PH_DECEL: begin
                      if (pos_reach_total) begin
                        fin_p_nxt = 1'b1;
                      end else begin
                        if (ram_rdata == '0) begin
                          half_nxt = HALF_MAX;
                        end else begin
                          need_div = 1'b1;
                        end
                        if (ptr_r != '0) begin
                          ptr_nxt = ptr_r - 1'b1;
                        end
                      end
                    end
                    PH_CRUISE: begin
                      if (pos_r >= decel_r) begin
                        phase_nxt = PH_DECEL;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
                if (fin_p_nxt) begin
                  phase_nxt = PH_STOP;
                  ptr_nxt   = '0;
                  pos_nxt   = '0;
                end else begin
                  pos_nxt = STEP_BITS'(pos_inc);
                end
              end
              if (!fin_p_nxt) begin
                if (short_r) begin
                  rel_p_nxt  = 1'b0;
                  cval_p_nxt = {1'b0, reload_r[SPEED_W-1:1]};
                end else begin
                  rel_p_nxt  = 1'b1;
                  cval_p_nxt = half_nxt;
                end
              end
            end
          end
          FUNC_STOP: begin
            fin_p_nxt = (phase_r != PH_STOP);
            phase_nxt = PH_STOP;
            ptr_nxt   = '0;
            pos_nxt   = '0;
            tog_nxt   = 1'b0;
            level_nxt = 1'b0;
          end
          default: begin
          end
        endcase
        if (need_div) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          half_nxt   = div_rsp.half;
          cval_p_nxt = div_rsp.half;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STOP;
      ptr_r       <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      decel_r     <= '0;
      half_r      <= '0;
      short_r     <= 1'b0;
      tog_r       <= 1'b0;
      level_r     <= 1'b0;
      dir_r       <= 1'b0;
      rlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ptr_r       <= ptr_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      decel_r     <= decel_nxt;
      half_r      <= half_nxt;
      short_r     <= short_nxt;
      tog_r       <= tog_nxt;
      level_r     <= level_nxt;
      dir_r       <= dir_nxt;
      rlen_r      <= rlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_q_r  <= func_q_nxt;
    steps_q_r <= steps_q_nxt;
    dir_q_r   <= dir_q_nxt;
    acc_p_r   <= acc_p_nxt;
    rel_p_r   <= rel_p_nxt;
    cval_p_r  <= cval_p_nxt;
    fin_p_r   <= fin_p_nxt;
    if (out_load) begin
      out_accepted         <= acc_p_r;
      out_step_level       <= level_r;
      out_direction        <= dir_r;
      out_enable           <= (phase_r != PH_STOP);
      out_phase            <= phase_r;
      out_compare_relative <= rel_p_r;
      out_compare_value    <= cval_p_r;
      out_position         <= pos_r;
      out_finished         <= fin_p_r;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_steps_r <= '0;
      reload_r     <= HALF_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RAMP_STEPS:   ramp_steps_r <= cfg_data[10:0];
        CFG_TIMER_RELOAD: reload_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_fin_stopped, ((state_r == ST_OUT) && fin_p_r) |-> (phase_r == PH_STOP), "finished move still running")
  `ASSERT_CLK(a_short_cruise, (short_r && (phase_r != PH_STOP)) |-> (phase_r == PH_CRUISE), "short move left cruise")
  `ASSERT_CLK(a_div_running, (state_r == ST_DIV) |-> (phase_r != PH_STOP), "half-period work while stopped")

endmodule
